// ===== sv/cbat_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Connection byte accounting package
// Shared codes, default table sizes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package cbat_pkg;

	localparam int META_DEPTH_DEF  = 64;
	localparam int STATS_DEPTH_DEF = 64;

	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	localparam int FLAG_SYN = 0;
	localparam int FLAG_ACK = 1;
	localparam int FLAG_RST = 2;
	localparam int FLAG_FIN = 3;

	typedef enum logic [1:0] {
		MODE_INGRESS = 2'd0,
		MODE_EGRESS  = 2'd1,
		MODE_CONNECT = 2'd2,
		MODE_CLOSE   = 2'd3
	} mode_t;

	localparam logic [1:0] META_NONE    = 2'd0;
	localparam logic [1:0] META_CREATED = 2'd1;
	localparam logic [1:0] META_DELETED = 2'd2;
	localparam logic [1:0] META_EVICTED = 2'd3;

	localparam logic [1:0] STATS_NONE    = 2'd0;
	localparam logic [1:0] STATS_CREATED = 2'd1;
	localparam logic [1:0] STATS_ADDED   = 2'd2;
	localparam logic [1:0] STATS_FULL    = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic load;
		logic scan_clr;
		logic scan_run;
		logic exec;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
	} status_t;

endpackage

// ===== sv/cbat_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Connection byte accounting controller
// Sequences load, table scan and update for one transaction at a time and
// owns the output valid register.
// ----------------------------------------------------------------------------
module cbat_ctrl
	import cbat_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	input  status_t sts,
	output cmd_t    cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_SCAN;
			ST_SCAN: if (sts.scan_done) state_d = ST_EXEC;
			ST_EXEC: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load     = in_valid;
				cmd.scan_clr = in_valid;
			end
			ST_SCAN: cmd.scan_run = 1'b1;
			ST_EXEC: cmd.exec = out_free;
			default: cmd = '0;
		endcase
	end

	// State and output valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== sv/cbat_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Connection byte accounting datapath
// Holds both tables, scans them one entry per cycle and applies the update.
// ----------------------------------------------------------------------------
module cbat_dpath
	import cbat_pkg::*;
#(
	parameter int META_DEPTH  = META_DEPTH_DEF,
	parameter int STATS_DEPTH = STATS_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output status_t     sts,
	input  logic [1:0]  mode,
	input  logic [63:0] cookie,
	input  logic [63:0] group_id,
	input  logic [63:0] now_time,
	input  logic [15:0] pkt_len,
	input  logic        parsed_ok,
	input  logic [7:0]  ip_proto,
	input  logic [31:0] src_addr,
	input  logic [31:0] dst_addr,
	input  logic [15:0] src_port_num,
	input  logic [15:0] dst_port_num,
	input  logic [3:0]  tcp_flags,
	output logic        pass_packet,
	output logic [1:0]  meta_action,
	output logic [1:0]  stats_action,
	output logic [5:0]  stats_slot,
	output logic [63:0] tx_total,
	output logic [63:0] rx_total,
	output logic        recorded_direction,
	output logic        recorded_pod_init
);

	localparam int MAW    = $clog2(META_DEPTH);
	localparam int SAW    = $clog2(STATS_DEPTH);
	localparam int SCAN_N = (META_DEPTH > STATS_DEPTH) ? META_DEPTH : STATS_DEPTH;
	localparam int CW     = $clog2(SCAN_N + 1);
	localparam logic [CW-1:0] SCAN_LAST = CW'(SCAN_N);
	localparam logic [CW-1:0] META_END  = CW'(META_DEPTH);
	localparam logic [CW-1:0] STATS_END = CW'(STATS_DEPTH);

	// Table storage.
	logic [63:0]  meta_key_mem  [META_DEPTH];
	logic [64:0]  meta_gp_mem   [META_DEPTH];
	logic [63:0]  meta_last_mem [META_DEPTH];
	logic [63:0]  stat_key_mem  [STATS_DEPTH];
	logic [167:0] stat_info_mem [STATS_DEPTH];
	logic [1:0]   stat_dp_mem   [STATS_DEPTH];
	logic [63:0]  stat_tx_mem   [STATS_DEPTH];
	logic [63:0]  stat_rx_mem   [STATS_DEPTH];
	logic [META_DEPTH-1:0]  meta_vld_q;
	logic [STATS_DEPTH-1:0] stat_vld_q;

	// Captured transaction.
	mode_t        mode_q;
	logic [63:0]  cookie_q, group_q, now_q;
	logic [15:0]  len_q;
	logic         ok_q;
	logic [7:0]   proto_q;
	logic [103:0] tuple_q;
	logic [3:0]   flags_q;

	// Scan pipeline.
	logic [CW-1:0] cnt_q, idx_s1;
	logic          v_s1;
	logic [63:0]   m_key_s1, m_last_s1, s_key_s1, s_tx_s1, s_rx_s1;
	logic [64:0]   m_gp_s1;
	logic [1:0]    s_dp_s1;
	logic          m_ok, s_ok, m_vld, s_vld, m_hit_now, s_hit_now;

	// Scan results.
	logic           mhit_q, mfree_q, shit_q, sfree_q;
	logic [MAW-1:0] midx_q, mfree_idx_q, mmin_idx_q;
	logic [SAW-1:0] sidx_q, sfree_idx_q;
	logic [63:0]    mmin_val_q, mgrp_q, stx_q, srx_q;
	logic           mpod_q;
	logic [1:0]     sdp_q;

	assign sts.scan_done = (cnt_q == SCAN_LAST);

	// Load the incoming transaction.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= mode_t'(mode);
			cookie_q <= cookie;
			group_q <= group_id;
			now_q   <= now_time;
			len_q   <= pkt_len;
			ok_q    <= parsed_ok;
			proto_q <= ip_proto;
			tuple_q <= {src_addr, dst_addr, src_port_num, dst_port_num, ip_proto};
			flags_q <= tcp_flags;
		end
	end

	// Scan counter and stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			v_s1  <= 1'b0;
		end else if (cmd.scan_clr) begin
			cnt_q <= '0;
			v_s1  <= 1'b0;
		end else if (cmd.scan_run) begin
			v_s1 <= (cnt_q != SCAN_LAST);
			if (cnt_q != SCAN_LAST) cnt_q <= cnt_q + 1'b1;
		end else begin
			v_s1 <= 1'b0;
		end
	end

	// Registered table reads at the scan address.
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		if (cmd.scan_run && cnt_q < META_END) begin
			m_key_s1  <= meta_key_mem[cnt_q[MAW-1:0]];
			m_gp_s1   <= meta_gp_mem[cnt_q[MAW-1:0]];
			m_last_s1 <= meta_last_mem[cnt_q[MAW-1:0]];
		end
		if (cmd.scan_run && cnt_q < STATS_END) begin
			s_key_s1 <= stat_key_mem[cnt_q[SAW-1:0]];
			s_dp_s1  <= stat_dp_mem[cnt_q[SAW-1:0]];
			s_tx_s1  <= stat_tx_mem[cnt_q[SAW-1:0]];
			s_rx_s1  <= stat_rx_mem[cnt_q[SAW-1:0]];
		end
	end

	// Compare the entry read last cycle.
	assign m_ok      = v_s1 && (idx_s1 < META_END);
	assign s_ok      = v_s1 && (idx_s1 < STATS_END);
	assign m_vld     = m_ok && meta_vld_q[idx_s1[MAW-1:0]];
	assign s_vld     = s_ok && stat_vld_q[idx_s1[SAW-1:0]];
	assign m_hit_now = m_vld && (m_key_s1 == cookie_q) && !mhit_q;
	assign s_hit_now = s_vld && (s_key_s1 == cookie_q) && !shit_q;

	// Scan flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mhit_q  <= 1'b0;
			mfree_q <= 1'b0;
			shit_q  <= 1'b0;
			sfree_q <= 1'b0;
		end else if (cmd.scan_clr) begin
			mhit_q  <= 1'b0;
			mfree_q <= 1'b0;
			shit_q  <= 1'b0;
			sfree_q <= 1'b0;
		end else begin
			if (m_hit_now) mhit_q <= 1'b1;
			if (m_ok && !m_vld) mfree_q <= 1'b1;
			if (s_hit_now) shit_q <= 1'b1;
			if (s_ok && !s_vld) sfree_q <= 1'b1;
		end
	end

	// Scan payload: hit data, first free slot and oldest entry.
	always_ff @(posedge clk) begin
		if (m_hit_now) begin
			midx_q <= idx_s1[MAW-1:0];
			mgrp_q <= m_gp_s1[64:1];
			mpod_q <= m_gp_s1[0];
		end
		if (m_ok && !m_vld && !mfree_q) mfree_idx_q <= idx_s1[MAW-1:0];
		if (m_ok && (idx_s1 == '0 || m_last_s1 < mmin_val_q)) begin
			mmin_idx_q <= idx_s1[MAW-1:0];
			mmin_val_q <= m_last_s1;
		end
		if (s_hit_now) begin
			sidx_q <= idx_s1[SAW-1:0];
			sdp_q  <= s_dp_s1;
			stx_q  <= s_tx_s1;
			srx_q  <= s_rx_s1;
		end
		if (s_ok && !s_vld && !sfree_q) sfree_idx_q <= idx_s1[SAW-1:0];
	end

	// Update decision.
	logic        dir, is_pkt, is_tcp, is_udp, pkt_go, syn_first, closing;
	logic        m_ins, m_del, m_refresh, do_create, do_add, create_pod;
	logic [63:0] create_grp, len64, new_tx, new_rx, add_tx, add_rx;

	assign dir       = (mode_q == MODE_INGRESS);
	assign is_pkt    = (mode_q == MODE_INGRESS) || (mode_q == MODE_EGRESS);
	assign is_tcp    = (proto_q == PROTO_TCP);
	assign is_udp    = (proto_q == PROTO_UDP);
	assign pkt_go    = (cookie_q != '0) && ok_q && (is_tcp || is_udp);
	assign syn_first = flags_q[FLAG_SYN] && !flags_q[FLAG_ACK];
	assign closing   = !syn_first && (flags_q[FLAG_RST] || flags_q[FLAG_FIN]);
	assign len64     = {48'd0, len_q};
	assign new_tx    = dir ? 64'd0 : len64;
	assign new_rx    = dir ? len64 : 64'd0;
	assign add_tx    = dir ? stx_q : stx_q + len64;
	assign add_rx    = dir ? srx_q + len64 : srx_q;

	always_comb begin
		m_ins      = 1'b0;
		m_del      = 1'b0;
		m_refresh  = 1'b0;
		do_create  = 1'b0;
		do_add     = 1'b0;
		create_grp = group_q;
		create_pod = !dir;
		unique case (mode_q)
			MODE_CONNECT: m_ins = !mhit_q;
			MODE_CLOSE: m_del = ok_q && (cookie_q != '0) && mhit_q;
			MODE_INGRESS, MODE_EGRESS: begin
				if (pkt_go && is_tcp) begin
					if (mhit_q && !shit_q) begin
						m_refresh  = 1'b1;
						do_create  = 1'b1;
						create_grp = mgrp_q;
						create_pod = mpod_q;
					end else if (shit_q && (mhit_q || !closing)) begin
						do_add = 1'b1;
					end
					m_del = closing && mhit_q;
				end else if (pkt_go) begin
					do_create = !shit_q;
					do_add    = shit_q;
				end
			end
			default: m_ins = 1'b0;
		endcase
	end

	// Table writes.
	logic [MAW-1:0] m_ins_idx;
	logic [SAW-1:0] s_widx;
	logic           s_create_wr, s_cnt_wr;

	assign m_ins_idx   = mfree_q ? mfree_idx_q : mmin_idx_q;
	assign s_widx      = do_create ? sfree_idx_q : sidx_q;
	assign s_create_wr = cmd.exec && do_create && sfree_q;
	assign s_cnt_wr    = s_create_wr || (cmd.exec && do_add);

	always_ff @(posedge clk) begin
		if (cmd.exec && m_ins) begin
			meta_key_mem[m_ins_idx]  <= cookie_q;
			meta_gp_mem[m_ins_idx]   <= {group_q, 1'b1};
			meta_last_mem[m_ins_idx] <= now_q;
		end else if (cmd.exec && m_refresh) begin
			meta_last_mem[midx_q] <= now_q;
		end
		if (s_create_wr) begin
			stat_key_mem[s_widx]  <= cookie_q;
			stat_info_mem[s_widx] <= {create_grp, tuple_q};
			stat_dp_mem[s_widx]   <= {create_pod, dir};
		end
		if (s_cnt_wr) begin
			stat_tx_mem[s_widx] <= do_create ? new_tx : add_tx;
			stat_rx_mem[s_widx] <= do_create ? new_rx : add_rx;
		end
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_vld_q <= '0;
			stat_vld_q <= '0;
		end else begin
			if (cmd.exec && m_ins) meta_vld_q[m_ins_idx] <= 1'b1;
			if (cmd.exec && m_del) meta_vld_q[midx_q] <= 1'b0;
			if (s_create_wr) stat_vld_q[sfree_idx_q] <= 1'b1;
		end
	end

	// Result registers.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			pass_packet        <= !(is_pkt && cookie_q == '0);
			meta_action        <= m_ins ? (mfree_q ? META_CREATED : META_EVICTED)
			                            : (m_del ? META_DELETED : META_NONE);
			stats_action       <= STATS_NONE;
			stats_slot         <= '0;
			tx_total           <= '0;
			rx_total           <= '0;
			recorded_direction <= 1'b0;
			recorded_pod_init  <= 1'b0;
			if (do_create && sfree_q) begin
				stats_action       <= STATS_CREATED;
				stats_slot         <= 6'(sfree_idx_q);
				tx_total           <= new_tx;
				rx_total           <= new_rx;
				recorded_direction <= dir;
				recorded_pod_init  <= create_pod;
			end else if (do_create) begin
				stats_action <= STATS_FULL;
			end else if (do_add) begin
				stats_action       <= STATS_ADDED;
				stats_slot         <= 6'(sidx_q);
				tx_total           <= add_tx;
				rx_total           <= add_rx;
				recorded_direction <= sdp_q[0];
				recorded_pod_init  <= sdp_q[1];
			end
		end
	end

endmodule

// ===== sv/connection_byte_accounting_table.sv =====
`timescale 1ns / 1ps
// An accepted transaction is loaded, then the key scan reads the table memories
// one entry per cycle over max(META_DEPTH, STATS_DEPTH) entries, and then the
// update is applied and its result registered. A new transaction is taken only
// after the update of the last one. Reset clears all valid bits at once;
// no clearing pass is needed and the block accepts input right after reset.
// ----------------------------------------------------------------------------
// Connection byte accounting table
// Cookie-keyed metadata and statistics tables with LRU eviction.
// ----------------------------------------------------------------------------
module connection_byte_accounting_table
	import cbat_pkg::*;
#(
	parameter int META_DEPTH  = META_DEPTH_DEF,
	parameter int STATS_DEPTH = STATS_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [63:0] cookie,
	input  logic [63:0] group_id,
	input  logic [63:0] now_time,
	input  logic [15:0] pkt_len,
	input  logic        parsed_ok,
	input  logic [7:0]  ip_proto,
	input  logic [31:0] src_addr,
	input  logic [31:0] dst_addr,
	input  logic [15:0] src_port_num,
	input  logic [15:0] dst_port_num,
	input  logic [3:0]  tcp_flags,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        pass_packet,
	output logic [1:0]  meta_action,
	output logic [1:0]  stats_action,
	output logic [5:0]  stats_slot,
	output logic [63:0] tx_total,
	output logic [63:0] rx_total,
	output logic        recorded_direction,
	output logic        recorded_pod_init
);

	cmd_t    cmd;
	status_t sts;

	// Sequencer.
	cbat_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Tables and update logic.
	cbat_dpath #(
		.META_DEPTH  (META_DEPTH),
		.STATS_DEPTH (STATS_DEPTH)
	) u_dpath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.mode               (mode),
		.cookie             (cookie),
		.group_id           (group_id),
		.now_time           (now_time),
		.pkt_len            (pkt_len),
		.parsed_ok          (parsed_ok),
		.ip_proto           (ip_proto),
		.src_addr           (src_addr),
		.dst_addr           (dst_addr),
		.src_port_num       (src_port_num),
		.dst_port_num       (dst_port_num),
		.tcp_flags          (tcp_flags),
		.pass_packet        (pass_packet),
		.meta_action        (meta_action),
		.stats_action       (stats_action),
		.stats_slot         (stats_slot),
		.tx_total           (tx_total),
		.rx_total           (rx_total),
		.recorded_direction (recorded_direction),
		.recorded_pod_init  (recorded_pod_init)
	);

	// An update always presents a result on the next cycle.
	a_exec_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> out_valid)
		else $error("result not presented after update");

	// The block is busy right after accepting a transaction.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while a transaction is in flight");

	// A dropped packet touches neither table.
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !pass_packet) |->
		(meta_action == META_NONE && stats_action == STATS_NONE))
		else $error("dropped packet changed a table");

	// A failed insert reports no entry.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && stats_action == STATS_FULL) |->
		(stats_slot == '0 && tx_total == '0 && rx_total == '0))
		else $error("failed insert reported entry data");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Connection byte accounting table testbench
// A directed sequence is followed by random packets and socket events on a
// small cookie pool, so both tables fill, the metadata table evicts and the
// statistics table overflows. A scoreboard models the two tables and checks
// every result in order. The input idles and the output stalls at random.
// ----------------------------------------------------------------------------
module tb_top;
	import cbat_pkg::*;

	localparam int NUM_RANDOM  = 650;
	localparam int POOL_SIZE   = 96;
	localparam int CYCLE_LIMIT = 600000;

	// One input transaction.
	typedef struct {
		logic [1:0]  mode;
		logic [63:0] cookie;
		logic [63:0] group_id;
		logic [63:0] now_time;
		logic [15:0] pkt_len;
		logic        parsed_ok;
		logic [7:0]  ip_proto;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] src_port_num;
		logic [15:0] dst_port_num;
		logic [3:0]  tcp_flags;
	} pkt_item_t;

	// One result transaction.
	typedef struct {
		logic        pass_packet;
		logic [1:0]  meta_action;
		logic [1:0]  stats_action;
		logic [5:0]  stats_slot;
		logic [63:0] tx_total;
		logic [63:0] rx_total;
		logic        recorded_direction;
		logic        recorded_pod_init;
	} acct_result_t;

	// Table model plus the queue of expected results.
	class acct_scoreboard;
		bit          meta_used [META_DEPTH_DEF];
		logic [63:0] meta_cookie [META_DEPTH_DEF];
		logic        meta_pod [META_DEPTH_DEF];
		logic [63:0] meta_stamp [META_DEPTH_DEF];
		bit          stat_used [STATS_DEPTH_DEF];
		logic [63:0] stat_cookie [STATS_DEPTH_DEF];
		logic [1:0]  stat_flags [STATS_DEPTH_DEF];
		logic [63:0] stat_txb [STATS_DEPTH_DEF];
		logic [63:0] stat_rxb [STATS_DEPTH_DEF];
		acct_result_t expected_results [$];
		int errors;
		int evictions;
		int full_hits;
		int closes;

		function new();
			errors = 0;
			evictions = 0;
			full_hits = 0;
			closes = 0;
			foreach (meta_used[i]) meta_used[i] = 0;
			foreach (stat_used[i]) stat_used[i] = 0;
		endfunction

		function int find_meta(logic [63:0] key);
			for (int i = 0; i < META_DEPTH_DEF; i++)
				if (meta_used[i] && meta_cookie[i] == key)
					return i;
			return -1;
		endfunction

		function int find_stat(logic [63:0] key);
			for (int i = 0; i < STATS_DEPTH_DEF; i++)
				if (stat_used[i] && stat_cookie[i] == key)
					return i;
			return -1;
		endfunction

		function void report_slot(int s, ref acct_result_t r);
			r.stats_slot = s[5:0];
			r.tx_total = stat_txb[s];
			r.rx_total = stat_rxb[s];
			r.recorded_direction = stat_flags[s][0];
			r.recorded_pod_init = stat_flags[s][1];
		endfunction

		function void create_stat(logic [63:0] key, logic dir, logic pod,
				logic [15:0] len, ref acct_result_t r);
			for (int i = 0; i < STATS_DEPTH_DEF; i++) begin
				if (!stat_used[i]) begin
					stat_used[i] = 1;
					stat_cookie[i] = key;
					stat_flags[i] = {pod, dir};
					stat_txb[i] = dir ? 64'd0 : 64'(len);
					stat_rxb[i] = dir ? 64'(len) : 64'd0;
					r.stats_action = STATS_CREATED;
					report_slot(i, r);
					return;
				end
			end
			r.stats_action = STATS_FULL;
			full_hits++;
		endfunction

		function void add_stat(int s, logic dir, logic [15:0] len, ref acct_result_t r);
			if (dir)
				stat_rxb[s] = stat_rxb[s] + 64'(len);
			else
				stat_txb[s] = stat_txb[s] + 64'(len);
			r.stats_action = STATS_ADDED;
			report_slot(s, r);
		endfunction

		// Apply one accepted input to the model and queue its result.
		function void note_input(pkt_item_t it);
			acct_result_t r;
			int m;
			int s;
			logic dir;
			logic syn_code;
			logic closing;
			r = '{default: '0};
			r.pass_packet = 1'b1;
			if (it.mode == MODE_CONNECT) begin
				if (find_meta(it.cookie) < 0) begin
					m = -1;
					for (int i = 0; i < META_DEPTH_DEF && m < 0; i++)
						if (!meta_used[i])
							m = i;
					r.meta_action = META_CREATED;
					if (m < 0) begin
						m = 0;
						for (int i = 1; i < META_DEPTH_DEF; i++)
							if (meta_stamp[i] < meta_stamp[m])
								m = i;
						r.meta_action = META_EVICTED;
						evictions++;
					end
					meta_used[m] = 1;
					meta_cookie[m] = it.cookie;
					meta_pod[m] = 1'b1;
					meta_stamp[m] = it.now_time;
				end
			end else if (it.mode == MODE_CLOSE) begin
				if (it.parsed_ok && it.cookie != 0) begin
					m = find_meta(it.cookie);
					if (m >= 0) begin
						meta_used[m] = 0;
						r.meta_action = META_DELETED;
						closes++;
					end
				end
			end else if (it.cookie == 0) begin
				r.pass_packet = 1'b0;
			end else if (it.parsed_ok && (it.ip_proto == PROTO_TCP || it.ip_proto == PROTO_UDP)) begin
				dir = (it.mode == MODE_INGRESS);
				s = find_stat(it.cookie);
				m = find_meta(it.cookie);
				if (it.ip_proto == PROTO_TCP) begin
					syn_code = it.tcp_flags[FLAG_SYN] && !it.tcp_flags[FLAG_ACK];
					closing = !syn_code && (it.tcp_flags[FLAG_RST] || it.tcp_flags[FLAG_FIN]);
					if (m >= 0 && s < 0) begin
						meta_stamp[m] = it.now_time;
						create_stat(it.cookie, dir, meta_pod[m], it.pkt_len, r);
					end else if (s >= 0 && (m >= 0 || !closing)) begin
						add_stat(s, dir, it.pkt_len, r);
					end
					if (closing && m >= 0) begin
						meta_used[m] = 0;
						r.meta_action = META_DELETED;
						closes++;
					end
				end else if (s < 0) begin
					create_stat(it.cookie, dir, !dir, it.pkt_len, r);
				end else begin
					add_stat(s, dir, it.pkt_len, r);
				end
			end
			expected_results.push_back(r);
		endfunction

		function void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
			if (exp_v !== act_v) begin
				$error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
				errors++;
			end
		endfunction

		// Compare one accepted result with the oldest expectation.
		function void check_result(acct_result_t act);
			acct_result_t e;
			if (expected_results.size() == 0) begin
				$error("result transaction with no expectation pending");
				errors++;
				return;
			end
			e = expected_results.pop_front();
			check_field("pass_packet", e.pass_packet, act.pass_packet);
			check_field("meta_action", e.meta_action, act.meta_action);
			check_field("stats_action", e.stats_action, act.stats_action);
			check_field("stats_slot", e.stats_slot, act.stats_slot);
			check_field("tx_total", e.tx_total, act.tx_total);
			check_field("rx_total", e.rx_total, act.rx_total);
			check_field("recorded_direction", e.recorded_direction, act.recorded_direction);
			check_field("recorded_pod_init", e.recorded_pod_init, act.recorded_pod_init);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  mode;
	logic [63:0] cookie;
	logic [63:0] group_id;
	logic [63:0] now_time;
	logic [15:0] pkt_len;
	logic        parsed_ok;
	logic [7:0]  ip_proto;
	logic [31:0] src_addr;
	logic [31:0] dst_addr;
	logic [15:0] src_port_num;
	logic [15:0] dst_port_num;
	logic [3:0]  tcp_flags;
	logic        out_valid;
	logic        out_stall;
	logic        pass_packet;
	logic [1:0]  meta_action;
	logic [1:0]  stats_action;
	logic [5:0]  stats_slot;
	logic [63:0] tx_total;
	logic [63:0] rx_total;
	logic        recorded_direction;
	logic        recorded_pod_init;

	acct_scoreboard sb;
	logic [63:0] cookie_pool [POOL_SIZE];
	int results_seen;
	int items_sent;
	int cycle_count;
	bit hold_done;

	connection_byte_accounting_table dut (.*);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Cycle limit on the whole run.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycle_count);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// Random gap length: mostly short, now and then long.
	function automatic int gap_len();
		if ($urandom_range(0, 2) == 0)
			return 0;
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(20, 150);
		return $urandom_range(0, 4);
	endfunction

	// Offer one transaction after an idle gap and wait for its acceptance.
	task automatic send_item(pkt_item_t it);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= it.mode;
		cookie <= it.cookie;
		group_id <= it.group_id;
		now_time <= it.now_time;
		pkt_len <= it.pkt_len;
		parsed_ok <= it.parsed_ok;
		ip_proto <= it.ip_proto;
		src_addr <= it.src_addr;
		dst_addr <= it.dst_addr;
		src_port_num <= it.src_port_num;
		dst_port_num <= it.dst_port_num;
		tcp_flags <= it.tcp_flags;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_input(it);
		items_sent++;
	endtask

	function automatic pkt_item_t make_item(logic [1:0] md, logic [63:0] ck,
			logic [7:0] proto, logic [3:0] flags, logic [15:0] len, logic ok);
		pkt_item_t it;
		it.mode = md;
		it.cookie = ck;
		it.group_id = {$urandom, $urandom};
		it.now_time = {$urandom, $urandom};
		it.pkt_len = len;
		it.parsed_ok = ok;
		it.ip_proto = proto;
		it.src_addr = $urandom;
		it.dst_addr = $urandom;
		it.src_port_num = 16'($urandom);
		it.dst_port_num = 16'($urandom);
		it.tcp_flags = flags;
		return it;
	endfunction

	// Random transaction, mostly well-formed traffic on pooled cookies.
	function automatic pkt_item_t random_item();
		logic [1:0]  md;
		logic [63:0] ck;
		logic [7:0]  proto;
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 20)
			md = MODE_CONNECT;
		else if (sel < 30)
			md = MODE_CLOSE;
		else
			md = sel[0] ? MODE_INGRESS : MODE_EGRESS;
		sel = $urandom_range(0, 99);
		if (sel < 3)
			ck = 64'd0;
		else if (sel < 6)
			ck = {$urandom, $urandom};
		else
			ck = cookie_pool[$urandom_range(0, POOL_SIZE - 1)];
		sel = $urandom_range(0, 99);
		if (sel < 55)
			proto = PROTO_TCP;
		else if (sel < 92)
			proto = PROTO_UDP;
		else
			proto = 8'($urandom);
		return make_item(md, ck, proto, 4'($urandom), 16'($urandom),
			$urandom_range(0, 19) != 0);
	endfunction

	// Result side: random stall, one long hold-off, a stall-free window, and the checks.
	initial begin
		int hold;
		out_stall = 1'b0;
		results_seen = 0;
		hold_done = 0;
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				sb.check_result('{pass_packet, meta_action, stats_action, stats_slot,
					tx_total, rx_total, recorded_direction, recorded_pod_init});
				results_seen++;
			end
			if (hold > 0) begin
				hold--;
				out_stall <= 1'b1;
			end else if (!hold_done && results_seen == 150) begin
				hold_done = 1;
				hold = 800;
				out_stall <= 1'b1;
			end else if (results_seen > 300 && results_seen < 360) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(0, 3) == 0);
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		logic [63:0] ca;
		logic [63:0] cb;
		sb = new();
		items_sent = 0;
		foreach (cookie_pool[i])
			cookie_pool[i] = {$urandom, $urandom} | 64'd1;
		cookie_pool[0] = '1;
		ca = cookie_pool[1];
		cb = cookie_pool[2];
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_INGRESS;
		cookie = '0;
		group_id = '0;
		now_time = '0;
		pkt_len = '0;
		parsed_ok = 1'b0;
		ip_proto = '0;
		src_addr = '0;
		dst_addr = '0;
		src_port_num = '0;
		dst_port_num = '0;
		tcp_flags = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: each branch of the packet and event handling that needs no full table.
		send_item(make_item(MODE_CONNECT, ca, PROTO_TCP, 4'h0, 16'd0, 1'b1));
		send_item(make_item(MODE_CONNECT, ca, PROTO_TCP, 4'h0, 16'd0, 1'b1));
		send_item(make_item(MODE_INGRESS, ca, PROTO_TCP, 4'b0001, 16'hFFFF, 1'b1));
		send_item(make_item(MODE_EGRESS, ca, PROTO_TCP, 4'b0010, 16'hFFFF, 1'b1));
		send_item(make_item(MODE_EGRESS, ca, PROTO_TCP, 4'b0101, 16'd1, 1'b1));
		send_item(make_item(MODE_INGRESS, ca, PROTO_TCP, 4'b1010, 16'd7, 1'b1));
		send_item(make_item(MODE_INGRESS, ca, PROTO_TCP, 4'b0110, 16'd9, 1'b1));
		send_item(make_item(MODE_EGRESS, ca, PROTO_TCP, 4'b0010, 16'd3, 1'b1));
		send_item(make_item(MODE_INGRESS, cb, PROTO_TCP, 4'b0010, 16'd5, 1'b1));
		send_item(make_item(MODE_INGRESS, cb, PROTO_UDP, 4'h0, 16'd100, 1'b1));
		send_item(make_item(MODE_EGRESS, cb, PROTO_UDP, 4'hF, 16'hFFFF, 1'b1));
		send_item(make_item(MODE_EGRESS, cookie_pool[3], PROTO_UDP, 4'h0, 16'd0, 1'b1));
		send_item(make_item(MODE_INGRESS, 64'd0, PROTO_UDP, 4'h0, 16'd4, 1'b1));
		send_item(make_item(MODE_EGRESS, cb, PROTO_UDP, 4'h0, 16'd4, 1'b0));
		send_item(make_item(MODE_EGRESS, cb, 8'hFF, 4'h0, 16'd4, 1'b1));
		send_item(make_item(MODE_CONNECT, cb, PROTO_UDP, 4'h0, 16'd0, 1'b1));
		send_item(make_item(MODE_CLOSE, cb, PROTO_UDP, 4'h0, 16'd0, 1'b0));
		send_item(make_item(MODE_CLOSE, 64'd0, PROTO_UDP, 4'h0, 16'd0, 1'b1));
		send_item(make_item(MODE_CLOSE, cb, PROTO_UDP, 4'h0, 16'd0, 1'b1));
		send_item(make_item(MODE_CLOSE, cb, PROTO_UDP, 4'h0, 16'd0, 1'b1));
		send_item(make_item(MODE_CONNECT, 64'd0, PROTO_UDP, 4'h0, 16'd0, 1'b1));

		// Random part, with one pause until the block drains.
		for (int n = 0; n < NUM_RANDOM; n++) begin
			if (n == 400) begin
				in_valid <= 1'b0;
				while (sb.expected_results.size() != 0) @(posedge clk);
			end
			send_item(random_item());
		end
		in_valid <= 1'b0;

		while (sb.expected_results.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (sb.expected_results.size() != 0) begin
			$error("%0d expected results never arrived", sb.expected_results.size());
			sb.errors++;
		end
		$display("Sent %0d transactions, checked %0d results in %0d cycles.",
			items_sent, results_seen, cycle_count);
		$display("Metadata evictions %0d, deletions %0d, full statistics inserts %0d.",
			sb.evictions, sb.closes, sb.full_hits);
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
